// File: design/periodic_grid_fd_stencil_core_macros.svh
// ----------------------------------------------------------------------------
// Stencil core assertion macros
// Concurrent assertion shorthands, clocked on clk. They compile away when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_GRID_FD_STENCIL_CORE_MACROS_SVH
`define PERIODIC_GRID_FD_STENCIL_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked out of reset.
`define FDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next one.
`define FDS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define FDS_ASSERT(label, prop, msg)
`define FDS_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// File: design/fds_pkg.sv
// ----------------------------------------------------------------------------
// Stencil core package
// Shared widths, codes, the sequencer control bundle and saturation helpers.
// ----------------------------------------------------------------------------
package fds_pkg;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_XFIRST = 3'd2;
  localparam logic [2:0] REG_YFIRST = 3'd3;
  localparam logic [2:0] REG_XSEC  = 3'd4;
  localparam logic [2:0] REG_YSEC  = 3'd5;

  // Stencil taps, in read order
  localparam logic [3:0] TAP_C0 = 4'd0;
  localparam logic [3:0] TAP_R1 = 4'd1;
  localparam logic [3:0] TAP_R2 = 4'd2;
  localparam logic [3:0] TAP_L1 = 4'd3;
  localparam logic [3:0] TAP_L2 = 4'd4;
  localparam logic [3:0] TAP_U1 = 4'd5;
  localparam logic [3:0] TAP_U2 = 4'd6;
  localparam logic [3:0] TAP_D1 = 4'd7;
  localparam logic [3:0] TAP_D2 = 4'd8;

  localparam int SUM_W      = 24;  // weighted sums fit in 23 bits signed
  localparam int SCALE_W    = 24;
  localparam int RES_W      = 32;
  localparam int NUM_SUMS   = 8;   // x1, y1, x2, y2 for both parts
  localparam int NUM_SCALES = 4;
  localparam int PROD_W     = SUM_W + SCALE_W + 1;

  // Sum slots: x1 re/im, y1 re/im, x2 re/im, y2 re/im
  localparam logic [2:0] SLOT_LAST = 3'd7;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [RES_W-1:0] res_t;

  typedef struct packed {
    logic       clear;     // new evaluation starts
    logic       acc_en;    // read data valid for accumulation
    logic [3:0] acc_tap;   // which tap the read data belongs to
    logic       mul_go;    // issue one product
    logic [2:0] mul_slot;  // sum slot for the product
    logic       lap_go;    // form both Laplacian sums
  } ctl_t;

  function automatic res_t sat33(input logic signed [RES_W:0] v);
    res_t r;
    if (v[RES_W] != v[RES_W-1]) begin
      r = v[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

  function automatic logic ovf33(input logic signed [RES_W:0] v);
    return v[RES_W] ^ v[RES_W-1];
  endfunction

endpackage

// File: design/periodic_grid_fd_stencil_core.sv
// ----------------------------------------------------------------------------
// Periodic grid fourth-order stencil core
// Complex-sample grid store with x/y first derivatives and Laplacian.
// ----------------------------------------------------------------------------
// A write transfer stores one complex Q3.12 cell and gives no result. An
// evaluate transfer reads the cell and its eight neighbors (distance 1 and 2
// along both axes, wrapped at the rows/columns in use) from the single-port
// grid memory one cell per cycle, then runs the eight scaled sums through one
// shared 24x25 multiplier, one product per cycle, and adds the Laplacian pair.
// An in-range evaluation makes 9 memory reads and 8 products before its
// result is loaded; the input stalls until that load, so one evaluate holds
// the block from transfer to loaded result. Out-of-range coordinates return
// status 2 with zero results, loaded from the finish step with no reads or
// products. A full output register that is stalled holds the sequencer in
// its finish step until the old result moves on. The result sits in an
// output register, so a new item is taken while an old result waits. Cells
// must be written before being read; the store has no clear.
// ----------------------------------------------------------------------------
`include "periodic_grid_fd_stencil_core_macros.svh"

module periodic_grid_fd_stencil_core #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [15:0] sample_re,
  input  logic signed [15:0] sample_im,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] ddx_re,
  output logic signed [31:0] ddx_im,
  output logic signed [31:0] ddy_re,
  output logic signed [31:0] ddy_im,
  output logic signed [31:0] lap_re,
  output logic signed [31:0] lap_im,
  output logic [1:0]         status,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  // Address widths of the store, and a width for wrap arithmetic that holds
  // index + 2 and the 7-bit dimension registers.
  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int RDW = ($clog2(MAX_ROWS + 3) > 7) ? $clog2(MAX_ROWS + 3) : 7;
  localparam int CDW = ($clog2(MAX_COLS + 3) > 7) ? $clog2(MAX_COLS + 3) : 7;
  localparam int DW  = (RDW > CDW) ? RDW : CDW;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;  // one memory read per tap
  localparam logic [2:0] ST_SETTLE = 3'd2;  // last tap accumulates
  localparam logic [2:0] ST_MUL    = 3'd3;  // one product per sum slot
  localparam logic [2:0] ST_TAIL   = 3'd4;  // last product saturates
  localparam logic [2:0] ST_LAP    = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;  // wait for the output register

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [6:0]                  rows_cfg;
  logic [6:0]                  cols_cfg;
  logic [fds_pkg::SCALE_W-1:0] scales [fds_pkg::NUM_SCALES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= 7'd64;
      cols_cfg <= 7'd64;
      for (int k = 0; k < fds_pkg::NUM_SCALES; k++) begin
        scales[k] <= 24'd5461;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fds_pkg::REG_ROWS:   rows_cfg  <= cfg_data[6:0];
        fds_pkg::REG_COLS:   cols_cfg  <= cfg_data[6:0];
        fds_pkg::REG_XFIRST: scales[0] <= cfg_data;
        fds_pkg::REG_YFIRST: scales[1] <= cfg_data;
        fds_pkg::REG_XSEC:   scales[2] <= cfg_data;
        fds_pkg::REG_YSEC:   scales[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Grid period and neighbor indexes
  // --------------------------------------------------------------------------
  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
                                              input logic [DW-1:0] hi);
    logic [DW-1:0] r;
    if (v < DW'(4)) begin
      r = DW'(4);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // v +/- span modulo n, for v < n and n >= 4
  function automatic logic [DW-1:0] wrap_step(input logic [DW-1:0] v,
                                              input logic [DW-1:0] n,
                                              input logic [1:0]    span,
                                              input logic          fwd);
    logic [DW-1:0] t;
    logic [DW-1:0] r;
    if (fwd) begin
      t = v + DW'(span);
      r = (t >= n) ? t - n : t;
    end else begin
      r = (v < DW'(span)) ? v + n - DW'(span) : v - DW'(span);
    end
    return r;
  endfunction

  logic [DW-1:0] nr;
  logic [DW-1:0] nc;
  logic [DW-1:0] row_x;
  logic [DW-1:0] col_x;
  logic          in_grid;
  logic          in_store;

  assign nr       = clamp_dim(DW'(rows_cfg), DW'(MAX_ROWS));
  assign nc       = clamp_dim(DW'(cols_cfg), DW'(MAX_COLS));
  assign row_x    = DW'(row);
  assign col_x    = DW'(col);
  assign in_grid  = (row_x < nr) && (col_x < nc);
  assign in_store = (row_x < DW'(MAX_ROWS)) && (col_x < DW'(MAX_COLS));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [2:0]     state;
  logic [3:0]     tap;
  logic [2:0]     slot;
  logic           rd_valid;
  logic [3:0]     rd_tap;
  logic           range_err;
  logic           accept;
  logic           load;
  logic [RAW-1:0] row_q, ru1, ru2, rd1, rd2;
  logic [CAW-1:0] col_q, cr1, cr2, cl1, cl2;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap       <= fds_pkg::TAP_C0;
      slot      <= '0;
      rd_valid  <= 1'b0;
      range_err <= 1'b0;
    end else begin
      rd_valid <= (state == ST_READ);
      case (state)
        ST_IDLE: begin
          if (accept && command == fds_pkg::CMD_EVAL) begin
            tap       <= fds_pkg::TAP_C0;
            range_err <= !in_grid;
            state     <= in_grid ? ST_READ : ST_FINISH;
          end
        end
        ST_READ: begin
          tap <= tap + 4'd1;
          if (tap == fds_pkg::TAP_D2) begin
            state <= ST_SETTLE;
          end
        end
        ST_SETTLE: begin
          slot  <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          slot <= slot + 3'd1;
          if (slot == fds_pkg::SLOT_LAST) begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL:   state <= ST_LAP;
        ST_LAP:    state <= ST_FINISH;
        ST_FINISH: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Capture the cell and its wrapped neighbors at the evaluate transfer.
  always_ff @(posedge clk) begin
    rd_tap <= tap;
    if (accept) begin
      row_q <= RAW'(row_x);
      col_q <= CAW'(col_x);
      ru1   <= RAW'(wrap_step(row_x, nr, 2'd1, 1'b1));
      ru2   <= RAW'(wrap_step(row_x, nr, 2'd2, 1'b1));
      rd1   <= RAW'(wrap_step(row_x, nr, 2'd1, 1'b0));
      rd2   <= RAW'(wrap_step(row_x, nr, 2'd2, 1'b0));
      cr1   <= CAW'(wrap_step(col_x, nc, 2'd1, 1'b1));
      cr2   <= CAW'(wrap_step(col_x, nc, 2'd2, 1'b1));
      cl1   <= CAW'(wrap_step(col_x, nc, 2'd1, 1'b0));
      cl2   <= CAW'(wrap_step(col_x, nc, 2'd2, 1'b0));
    end
  end

  // --------------------------------------------------------------------------
  // Grid memory: writes in idle, stencil reads while in READ
  // --------------------------------------------------------------------------
  logic [RAW+CAW-1:0] mem_addr;
  logic [RAW+CAW-1:0] rd_addr;
  logic               mem_we;
  logic [31:0]        mem_rdata;

  always_comb begin
    case (tap)
      fds_pkg::TAP_C0: rd_addr = {row_q, col_q};
      fds_pkg::TAP_R1: rd_addr = {row_q, cr1};
      fds_pkg::TAP_R2: rd_addr = {row_q, cr2};
      fds_pkg::TAP_L1: rd_addr = {row_q, cl1};
      fds_pkg::TAP_L2: rd_addr = {row_q, cl2};
      fds_pkg::TAP_U1: rd_addr = {ru1, col_q};
      fds_pkg::TAP_U2: rd_addr = {ru2, col_q};
      fds_pkg::TAP_D1: rd_addr = {rd1, col_q};
      fds_pkg::TAP_D2: rd_addr = {rd2, col_q};
      default:         rd_addr = {row_q, col_q};
    endcase
  end

  assign mem_we   = accept && (command == fds_pkg::CMD_WRITE) && in_store;
  assign mem_addr = (state == ST_READ) ? rd_addr : {RAW'(row_x), CAW'(col_x)};

  fds_grid_mem #(
    .AW(RAW + CAW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ({sample_im, sample_re}),
    .rdata (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Datapath: tap accumulation, then the shared scale multiplier
  // --------------------------------------------------------------------------
  fds_pkg::ctl_t ctl;
  fds_pkg::sum_t sums [fds_pkg::NUM_SUMS];
  fds_pkg::res_t res  [fds_pkg::NUM_SUMS];
  fds_pkg::res_t lap_re_u;
  fds_pkg::res_t lap_im_u;
  logic          sat_any;

  always_comb begin
    ctl.clear    = accept && (command == fds_pkg::CMD_EVAL);
    ctl.acc_en   = rd_valid;
    ctl.acc_tap  = rd_tap;
    ctl.mul_go   = (state == ST_MUL);
    ctl.mul_slot = slot;
    ctl.lap_go   = (state == ST_LAP);
  end

  fds_tap_accum u_accum (
    .clk  (clk),
    .ctl  (ctl),
    .data (mem_rdata),
    .sums (sums)
  );

  fds_scale_unit u_scale (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sums    (sums),
    .scales  (scales),
    .res     (res),
    .lap_re  (lap_re_u),
    .lap_im  (lap_im_u),
    .sat_any (sat_any)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ddx_re <= range_err ? '0 : res[0];
      ddx_im <= range_err ? '0 : res[1];
      ddy_re <= range_err ? '0 : res[2];
      ddy_im <= range_err ? '0 : res[3];
      lap_re <= range_err ? '0 : lap_re_u;
      lap_im <= range_err ? '0 : lap_im_u;
      if (range_err) begin
        status <= fds_pkg::STATUS_RANGE;
      end else if (sat_any) begin
        status <= fds_pkg::STATUS_SAT;
      end else begin
        status <= fds_pkg::STATUS_OK;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FDS_ASSERT(a_lap_after_last_product, ctl.lap_go |-> ($past(state, 2) == ST_MUL && $past(slot, 2) == fds_pkg::SLOT_LAST), "Laplacian formed before the last product")
  `FDS_ASSERT(a_read_data_in_window, rd_valid |-> (state == ST_READ || state == ST_SETTLE), "memory read data outside the read window")
  `FDS_ASSERT(a_result_from_finish, $rose(out_valid) |-> $past(state) == ST_FINISH, "result loaded outside the finish step")
  `FDS_ASSERT(a_range_zero, (out_valid && status == fds_pkg::STATUS_RANGE) |-> (ddx_re == 0 && ddx_im == 0 && ddy_re == 0 && ddy_im == 0 && lap_re == 0 && lap_im == 0), "range error with nonzero results")
  `FDS_ASSERT_NEXT(a_finish_loads, (state == ST_FINISH && !(out_valid && out_stall)), (out_valid && state == ST_IDLE), "free output register not loaded")

endmodule

// File: design/fds_grid_mem.sv
// ----------------------------------------------------------------------------
// Grid memory
// Single-port cell store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module fds_grid_mem #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/fds_tap_accum.sv
// ----------------------------------------------------------------------------
// Tap accumulator
// Folds one grid cell per cycle into the eight weighted stencil sums.
// ----------------------------------------------------------------------------
module fds_tap_accum (
  input  logic            clk,
  input  fds_pkg::ctl_t   ctl,
  input  logic [31:0]     data,
  output fds_pkg::sum_t   sums [fds_pkg::NUM_SUMS]
);

  localparam int SW = fds_pkg::SUM_W;

  fds_pkg::sum_t add [fds_pkg::NUM_SUMS];

  // slot p: x1, 2+p: y1, 4+p: x2, 6+p: y2; p = 0 real, 1 imaginary
  always_comb begin : b_add
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] t8;
    logic signed [SW-1:0] t16;
    logic signed [SW-1:0] t30;
    for (int p = 0; p < 2; p++) begin
      v   = SW'(signed'(data[16*p +: 16]));
      t8  = v <<< 3;
      t16 = v <<< 4;
      t30 = (v <<< 5) - (v <<< 1);
      add[p]     = '0;
      add[2 + p] = '0;
      add[4 + p] = '0;
      add[6 + p] = '0;
      case (ctl.acc_tap)
        fds_pkg::TAP_C0: begin
          add[4 + p] = -t30;
          add[6 + p] = -t30;
        end
        fds_pkg::TAP_R1: begin
          add[p]     = t8;
          add[4 + p] = t16;
        end
        fds_pkg::TAP_R2: begin
          add[p]     = -v;
          add[4 + p] = -v;
        end
        fds_pkg::TAP_L1: begin
          add[p]     = -t8;
          add[4 + p] = t16;
        end
        fds_pkg::TAP_L2: begin
          add[p]     = v;
          add[4 + p] = -v;
        end
        fds_pkg::TAP_U1: begin
          add[2 + p] = t8;
          add[6 + p] = t16;
        end
        fds_pkg::TAP_U2: begin
          add[2 + p] = -v;
          add[6 + p] = -v;
        end
        fds_pkg::TAP_D1: begin
          add[2 + p] = -t8;
          add[6 + p] = t16;
        end
        fds_pkg::TAP_D2: begin
          add[2 + p] = v;
          add[6 + p] = -v;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int k = 0; k < fds_pkg::NUM_SUMS; k++) begin
        sums[k] <= '0;
      end
    end else if (ctl.acc_en) begin
      for (int k = 0; k < fds_pkg::NUM_SUMS; k++) begin
        sums[k] <= sums[k] + add[k];
      end
    end
  end

endmodule

// File: design/fds_scale_unit.sv
// ----------------------------------------------------------------------------
// Scale unit
// One shared multiplier: sum times Q8.16 scale, floor shift by 16, saturate.
// Also forms the saturated Laplacian sums and the sticky saturation flag.
// ----------------------------------------------------------------------------
module fds_scale_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  fds_pkg::ctl_t                 ctl,
  input  fds_pkg::sum_t                 sums [fds_pkg::NUM_SUMS],
  input  logic [fds_pkg::SCALE_W-1:0]   scales [fds_pkg::NUM_SCALES],
  output fds_pkg::res_t                 res [fds_pkg::NUM_SUMS],
  output fds_pkg::res_t                 lap_re,
  output fds_pkg::res_t                 lap_im,
  output logic                          sat_any
);

  localparam int RW = fds_pkg::RES_W;
  localparam int PW = fds_pkg::PROD_W;

  logic signed [PW-1:0]            prod;
  logic signed [PW-1:0]            prod_next;
  logic signed [fds_pkg::SCALE_W:0] scale_s;
  logic [2:0]                      slot_q;
  logic                            go_q;
  logic signed [RW:0]              q;
  logic signed [RW:0]              lap_re_sum;
  logic signed [RW:0]              lap_im_sum;

  assign scale_s    = {1'b0, scales[ctl.mul_slot[2:1]]};
  assign prod_next  = sums[ctl.mul_slot] * scale_s;
  // arithmetic shift is a floor division by 2^16
  assign q          = prod[PW-1:16];
  assign lap_re_sum = {res[4][RW-1], res[4]} + {res[6][RW-1], res[6]};
  assign lap_im_sum = {res[5][RW-1], res[5]} + {res[7][RW-1], res[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      go_q <= 1'b0;
    end else begin
      go_q <= ctl.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_go) begin
      prod   <= prod_next;
      slot_q <= ctl.mul_slot;
    end
    if (go_q) begin
      res[slot_q] <= fds_pkg::sat33(q);
    end
    if (ctl.lap_go) begin
      lap_re <= fds_pkg::sat33(lap_re_sum);
      lap_im <= fds_pkg::sat33(lap_im_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sat_any <= 1'b0;
    end else if (go_q && fds_pkg::ovf33(q)) begin
      sat_any <= 1'b1;
    end else if (ctl.lap_go && (fds_pkg::ovf33(lap_re_sum) || fds_pkg::ovf33(lap_im_sum))) begin
      sat_any <= 1'b1;
    end
  end

endmodule

// File: verif/fds_stencil_checker.sv
// ----------------------------------------------------------------------------
// Stencil core result checker
// Follows the configuration, cell-write and evaluate transfers, predicts each
// result from a private grid copy, and compares every result transfer field
// by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fds_stencil_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               command,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [15:0] sample_re,
  input  logic signed [15:0] sample_im,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] ddx_re,
  input  logic signed [31:0] ddx_im,
  input  logic signed [31:0] ddy_re,
  input  logic signed [31:0] ddy_im,
  input  logic signed [31:0] lap_re,
  input  logic signed [31:0] lap_im,
  input  logic [1:0]         status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 mismatches,
  output int                 pending,
  output int                 results_checked
);

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam longint RES_MAX = 64'sd2147483647;
  localparam longint RES_MIN = -64'sd2147483648;

  // val: ddx re/im, ddy re/im, lap re/im
  typedef struct packed {
    logic [1:0]            st;
    fds_pkg::res_t [5:0]   val;
  } deriv_set_t;

  deriv_set_t  awaited_q [$];
  logic [31:0] grid_cells [GRID_ROWS*GRID_COLS];
  logic [6:0]  rows_reg = 7'd64;
  logic [6:0]  cols_reg = 7'd64;
  logic [23:0] xf_reg = 24'd5461;
  logic [23:0] yf_reg = 24'd5461;
  logic [23:0] xs_reg = 24'd5461;
  logic [23:0] ys_reg = 24'd5461;
  bit          clip_hit;
  int          err_n = 0;
  int          seen_n = 0;
  string       field_names [6] = '{"ddx_re", "ddx_im", "ddy_re", "ddy_im",
                                   "lap_re", "lap_im"};

  function automatic int dim_in_use(input logic [6:0] v, input int hi);
    if (v < 7'd4) return 4;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic longint part_at(input int r, input int c, input int p);
    logic [31:0]        w;
    logic signed [15:0] h;
    w = grid_cells[r*GRID_COLS + c];
    h = (p != 0) ? w[31:16] : w[15:0];
    return h;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > RES_MAX) begin
      clip_hit = 1'b1;
      return RES_MAX;
    end
    if (v < RES_MIN) begin
      clip_hit = 1'b1;
      return RES_MIN;
    end
    return v;
  endfunction

  // floor shift: arithmetic shift of the signed product
  function automatic longint scaled(input longint sum, input logic [23:0] k);
    longint prod;
    prod = sum * longint'(k);
    return clip32(prod >>> 16);
  endfunction

  function automatic deriv_set_t stencil_at(input logic [5:0] r_in, input logic [5:0] c_in);
    deriv_set_t d;
    int         nr, nc, r, c, p;
    longint     ctr, e1, e2, w1, w2, n1, n2, s1, s2, lx, ly;
    d = '0;
    r = r_in;
    c = c_in;
    nr = dim_in_use(rows_reg, GRID_ROWS);
    nc = dim_in_use(cols_reg, GRID_COLS);
    if (r >= nr || c >= nc) begin
      d.st = fds_pkg::STATUS_RANGE;
      return d;
    end
    clip_hit = 1'b0;
    for (p = 0; p < 2; p++) begin
      ctr = part_at(r, c, p);
      e1  = part_at(r, (c + 1) % nc, p);
      e2  = part_at(r, (c + 2) % nc, p);
      w1  = part_at(r, (c + nc - 1) % nc, p);
      w2  = part_at(r, (c + nc - 2) % nc, p);
      n1  = part_at((r + 1) % nr, c, p);
      n2  = part_at((r + 2) % nr, c, p);
      s1  = part_at((r + nr - 1) % nr, c, p);
      s2  = part_at((r + nr - 2) % nr, c, p);
      d.val[p]     = fds_pkg::res_t'(scaled(-e2 + 8*e1 - 8*w1 + w2, xf_reg));
      d.val[2 + p] = fds_pkg::res_t'(scaled(-n2 + 8*n1 - 8*s1 + s2, yf_reg));
      lx = scaled(-e2 + 16*e1 - 30*ctr + 16*w1 - w2, xs_reg);
      ly = scaled(-n2 + 16*n1 - 30*ctr + 16*s1 - s2, ys_reg);
      d.val[4 + p] = fds_pkg::res_t'(clip32(lx + ly));
    end
    d.st = clip_hit ? fds_pkg::STATUS_SAT : fds_pkg::STATUS_OK;
    return d;
  endfunction

  always @(posedge clk) begin : watch
    deriv_set_t want, got;
    int         k;
    if (rst) begin
      awaited_q.delete();
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      xf_reg = 24'd5461;
      yf_reg = 24'd5461;
      xs_reg = 24'd5461;
      ys_reg = 24'd5461;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fds_pkg::REG_ROWS:   rows_reg = cfg_data[6:0];
          fds_pkg::REG_COLS:   cols_reg = cfg_data[6:0];
          fds_pkg::REG_XFIRST: xf_reg = cfg_data;
          fds_pkg::REG_YFIRST: yf_reg = cfg_data;
          fds_pkg::REG_XSEC:   xs_reg = cfg_data;
          fds_pkg::REG_YSEC:   ys_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (command == fds_pkg::CMD_WRITE) grid_cells[{row, col}] = {sample_im, sample_re};
        else awaited_q.push_back(stencil_at(row, col));
      end
      if (out_valid && !out_stall) begin
        got.st = status;
        got.val = {lap_im, lap_re, ddy_im, ddy_re, ddx_im, ddx_re};
        seen_n++;
        if (awaited_q.size() == 0) begin
          err_n++;
          $display("%0t result transfer with no evaluate pending: status %0d", $time,
                   status);
        end else begin
          want = awaited_q.pop_front();
          for (k = 0; k < 6; k++) begin
            if (got.val[k] !== want.val[k]) begin
              err_n++;
              $display("%0t %s wrong: expected %0d, actual %0d", $time, field_names[k],
                       $signed(want.val[k]), $signed(got.val[k]));
            end
          end
          if (got.st !== want.st) begin
            err_n++;
            $display("%0t status wrong: expected %0d, actual %0d", $time, want.st,
                     got.st);
          end
        end
      end
    end
    mismatches <= err_n;
    pending <= awaited_q.size();
    results_checked <= seen_n;
  end

endmodule

// File: verif/periodic_grid_fd_stencil_core_test.sv
// ----------------------------------------------------------------------------
// Stencil core testbench
// Drives cell writes and evaluates through the stall handshake under several
// grid sizes and scale settings, with random idling on both channels; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_grid_fd_stencil_core_test;

  localparam int CYCLE_LIMIT = 1_000_000;
  // an evaluate holds the block until its result is loaded; leave headroom before config writes and at the end
  localparam int DRAIN_CYCLES = 40;
  // indexes past the last register, which the block must ignore
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam logic [15:0] Q_MAX = 16'h7FFF;
  localparam logic [15:0] Q_MIN = 16'h8000;
  localparam logic [23:0] SCALE_MAX = 24'hFFFFFF;
  localparam logic [23:0] SCALE_RESET = 24'd5461;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               command;
  logic [5:0]         row;
  logic [5:0]         col;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] ddx_re, ddx_im, ddy_re, ddy_im, lap_re, lap_im;
  logic [1:0]         status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;

  int mismatches, pending, results_checked;

  // Stimulus bookkeeping: which store cells hold data, and the grid in use
  // (clamped as the block clamps it) so evaluates only touch written cells.
  bit cell_written [4096];
  int grid_rows = 64;
  int grid_cols = 64;
  bit calm = 1'b0;      // no idling on either side once set
  int cycle_count = 0;
  int n_items = 0, n_writes = 0, n_evals = 0, n_off_grid = 0;
  int n_cfg = 0, n_settings = 0;
  int stall_left = 0, quiet_left = 0;

  periodic_grid_fd_stencil_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .row       (row),
    .col       (col),
    .sample_re (sample_re),
    .sample_im (sample_im),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ddx_re    (ddx_re),
    .ddx_im    (ddx_im),
    .ddy_re    (ddy_re),
    .ddy_im    (ddy_im),
    .lap_re    (lap_re),
    .lap_im    (lap_im),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fds_stencil_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .row             (row),
    .col             (col),
    .sample_re       (sample_re),
    .sample_im       (sample_im),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .ddx_re          (ddx_re),
    .ddx_im          (ddx_im),
    .ddy_re          (ddy_re),
    .ddy_im          (ddy_im),
    .lap_re          (lap_re),
    .lap_im          (lap_im),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a correct run finishes far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
      $display("periodic_grid_fd_stencil_core: mismatch");
      $finish;
    end
  end

  // Result side back-pressure: random bursts of stall cycles, broken up by
  // quiet stretches with no stall at all; nothing once the run goes calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      quiet_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (quiet_left != 0) begin
      out_stall <= 1'b0;
      quiet_left <= quiet_left - 1;
    end else if ($urandom_range(0, 63) == 0) begin
      out_stall <= 1'b0;
      quiet_left <= $urandom_range(50, 200);
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 19) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int dim_from_reg(input logic [6:0] v);
    if (v < 7'd4) return 4;
    if (v > 7'd64) return 64;
    return int'(v);
  endfunction

  // Mostly random samples, with the Q3.12 extremes often enough to push the
  // weighted sums to their largest magnitudes.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      default: return 16'($urandom);
    endcase
  endfunction

  // One input transfer. Valid stays high from one item to the next unless a
  // random gap is taken, so it is never dropped and raised in one step.
  task automatic send_item(input logic cmd, input logic [5:0] r, input logic [5:0] c,
                           input logic [15:0] re, input logic [15:0] im);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    row <= r;
    col <= c;
    sample_re <= re;
    sample_im <= im;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (cmd == fds_pkg::CMD_WRITE) begin
      cell_written[{r, c}] = 1'b1;
      n_writes++;
    end else begin
      n_evals++;
    end
  endtask

  // Evaluate at an in-grid cell, first writing any of its nine taps that
  // were never written (the store has no defined contents until then).
  task automatic eval_filled(input int r, input int c);
    int k, tr, tc;
    for (k = 0; k < 9; k++) begin
      tr = r;
      tc = c;
      case (k)
        fds_pkg::TAP_R1: tc = c + 1;
        fds_pkg::TAP_R2: tc = c + 2;
        fds_pkg::TAP_L1: tc = c - 1;
        fds_pkg::TAP_L2: tc = c - 2;
        fds_pkg::TAP_U1: tr = r + 1;
        fds_pkg::TAP_U2: tr = r + 2;
        fds_pkg::TAP_D1: tr = r - 1;
        fds_pkg::TAP_D2: tr = r - 2;
        default: ;
      endcase
      tr = (tr + grid_rows) % grid_rows;
      tc = (tc + grid_cols) % grid_cols;
      if (!cell_written[tr*64 + tc])
        send_item(fds_pkg::CMD_WRITE, 6'(tr), 6'(tc), pick_sample(), pick_sample());
    end
    send_item(fds_pkg::CMD_EVAL, 6'(r), 6'(c), 16'($urandom), 16'($urandom));
  endtask

  // Stop sending, let every pending result arrive, then allow for work that
  // leaves no result before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Config valid is held across consecutive writes; the caller drops it.
  task automatic reg_write(input logic [2:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
    if (idx == fds_pkg::REG_ROWS) grid_rows = dim_from_reg(data[6:0]);
    if (idx == fds_pkg::REG_COLS) grid_cols = dim_from_reg(data[6:0]);
  endtask

  task automatic apply_settings(input logic [23:0] nr, input logic [23:0] nc,
                                input logic [23:0] xf, input logic [23:0] yf,
                                input logic [23:0] xs, input logic [23:0] ys,
                                input bit spare);
    settle();
    reg_write(fds_pkg::REG_ROWS, nr);
    reg_write(fds_pkg::REG_COLS, nc);
    reg_write(fds_pkg::REG_XFIRST, xf);
    reg_write(fds_pkg::REG_YFIRST, yf);
    reg_write(fds_pkg::REG_XSEC, xs);
    reg_write(fds_pkg::REG_YSEC, ys);
    if (spare) begin
      reg_write(REG_SPARE_LO, 24'($urandom));
      reg_write(REG_SPARE_HI, SCALE_MAX);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Random traffic: mostly filled-in evaluates, some evaluates off the grid
  // in use, the rest stray writes anywhere in the store.
  task automatic run_random(input int count);
    int stop_at, pick, r, c;
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        eval_filled($urandom_range(0, grid_rows - 1), $urandom_range(0, grid_cols - 1));
      end else if (pick < 65 && (grid_rows < 64 || grid_cols < 64)) begin
        if (grid_rows < 64 && (grid_cols == 64 || $urandom_range(0, 1) == 1)) begin
          r = $urandom_range(grid_rows, 63);
          c = $urandom_range(0, 63);
        end else begin
          r = $urandom_range(0, 63);
          c = $urandom_range(grid_cols, 63);
        end
        send_item(fds_pkg::CMD_EVAL, 6'(r), 6'(c), 16'($urandom), 16'($urandom));
        n_off_grid++;
      end else begin
        send_item(fds_pkg::CMD_WRITE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  pick_sample(), pick_sample());
      end
      // now and then hold off until the pipeline is empty
      if (!calm && $urandom_range(0, 149) == 0) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
    end
  endtask

  initial begin
    int r, c;
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= fds_pkg::CMD_WRITE;
    row <= '0;
    col <= '0;
    sample_re <= '0;
    sample_im <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= fds_pkg::REG_ROWS;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: smallest grid, largest scales, full-scale samples laid out
    // in halves so both derivatives and the Laplacian are large.
    apply_settings(24'd4, 24'd4, SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX, 1'b0);
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++)
        send_item(fds_pkg::CMD_WRITE, 6'(r), 6'(c), (c < 2) ? Q_MAX : Q_MIN,
                  (r < 2) ? Q_MAX : Q_MIN);
    // store cell outside the grid in use is still written
    send_item(fds_pkg::CMD_WRITE, 6'd63, 6'd63, Q_MAX, Q_MIN);
    send_item(fds_pkg::CMD_EVAL, 6'd0, 6'd0, Q_MIN, Q_MAX);
    send_item(fds_pkg::CMD_EVAL, 6'd3, 6'd3, 16'h0, 16'h0);
    send_item(fds_pkg::CMD_EVAL, 6'd1, 6'd2, 16'hFFFF, 16'h0);
    // coordinates off the grid in use: both, column only, row only
    send_item(fds_pkg::CMD_EVAL, 6'd63, 6'd63, 16'h0, 16'h0);
    send_item(fds_pkg::CMD_EVAL, 6'd0, 6'd4, 16'h0, 16'h0);
    send_item(fds_pkg::CMD_EVAL, 6'd4, 6'd0, 16'h0, 16'h0);
    n_off_grid += 3;

    // Random phases over a spread of settings. Out-of-range row/column
    // register values exercise the clamp; zero scales give all-zero results.
    apply_settings(24'd64, 24'd64, SCALE_RESET, SCALE_RESET, SCALE_RESET, SCALE_RESET, 1'b0);
    run_random(250);
    apply_settings(24'd0, 24'd127, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
    run_random(200);
    apply_settings(24'd64, 24'd4, 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom), 1'b0);
    run_random(250);
    apply_settings(24'd3, 24'd65, SCALE_MAX, 24'd1, SCALE_MAX, 24'd1, 1'b0);
    run_random(200);
    apply_settings(24'($urandom_range(4, 64)), 24'($urandom_range(4, 64)), 24'($urandom),
                   24'($urandom), 24'($urandom), 24'($urandom), 1'b0);
    run_random(250);

    // Last stretch back-to-back on both sides.
    calm = 1'b1;
    apply_settings(24'd5, 24'd7, 24'($urandom), SCALE_MAX, 24'($urandom), SCALE_MAX, 1'b0);
    run_random(250);
    settle();

    $display("covered %0d input transfers: %0d cell writes, %0d evaluates (%0d off grid)",
             n_items, n_writes, n_evals, n_off_grid);
    $display("%0d results compared over %0d register settings (%0d register writes)",
             results_checked, n_settings, n_cfg);
    if (mismatches == 0 && pending == 0) begin
      $display("periodic_grid_fd_stencil_core: match");
    end else begin
      $display("periodic_grid_fd_stencil_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/fds_pkg.sv
design/fds_grid_mem.sv
design/fds_tap_accum.sv
design/fds_scale_unit.sv
design/periodic_grid_fd_stencil_core.sv
verif/fds_stencil_checker.sv
verif/periodic_grid_fd_stencil_core_test.sv
